// ===== src/circle_collision_resolver_top_macros.svh =====
// ============================================================================
// Assertion macros for the circle collision resolver
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ============================================================================
`ifndef CIRCLE_COLLISION_RESOLVER_TOP_MACROS_SVH
`define CIRCLE_COLLISION_RESOLVER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CCR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/ccr_pkg.sv =====
// ============================================================================
// Circle collision resolver package
// Shared widths, constants, state and command types.
// ============================================================================
package ccr_pkg;

	localparam int POS_W      = 32;
	localparam int RAD_W      = 16;
	localparam int COEF_W     = 16;
	localparam int IDX_W      = 6;
	localparam int DIVIDEND_W = 48;
	localparam int DIVISOR_W  = 33;
	localparam int QUOT_W     = 16;
	localparam int SQ_IN_W    = 36;
	localparam int SQ_ROOT_W  = 18;

	localparam logic [COEF_W-1:0]  COEF_RESET  = 16'd49152;
	localparam logic [SQ_IN_W-1:0] SQ_BIT_INIT = 36'h4_0000_0000;

	typedef enum logic [4:0] {
		S_LOAD,
		S_RD_I,
		S_RD_J,
		S_CAP_J,
		S_DIFF,
		S_SQ,
		S_CMP,
		S_CHK,
		S_SQRT_W,
		S_OV,
		S_WEIGHT,
		S_PROD,
		S_DIV_SI,
		S_DIV_SI_W,
		S_DIV_SJ,
		S_DIV_SJ_W,
		S_UPD_MUL,
		S_UPD_DIV,
		S_UPD_DIV_W,
		S_UPD_WR,
		S_NEXT,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT_WAIT
	} ccr_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_WR,
		OP_CAP_I,
		OP_CAP_J,
		OP_DIFF,
		OP_SQ,
		OP_CMP,
		OP_SQRT_START,
		OP_OV,
		OP_WEIGHT,
		OP_PROD,
		OP_DIV_SI,
		OP_DIV_SJ,
		OP_UPD_MUL,
		OP_UPD_DIV,
		OP_UPD_WR
	} ccr_op_t;

	typedef enum logic [1:0] {
		DEST_SI,
		DEST_SJ,
		DEST_Q
	} ccr_dest_t;

	typedef struct packed {
		ccr_op_t          op;
		logic [IDX_W-1:0] addr;
		logic [1:0]       upd;
		logic             out_load;
		logic             out_last;
	} ccr_cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic near;
		logic len_zero;
	} ccr_status_t;

endpackage

// ===== src/ccr_ram.sv =====
// ============================================================================
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ============================================================================
module ccr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ccr_sqrt.sv =====
// ============================================================================
// Iterative integer square root
// Floor square root, one result bit per cycle.
// ============================================================================
module ccr_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ccr_pkg::SQ_IN_W-1:0]    operand,
	output logic                           done,
	output logic [ccr_pkg::SQ_ROOT_W-1:0]  root
);

	import ccr_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [SQ_IN_W-1:0] v_q;
	logic [SQ_IN_W-1:0] res_q;
	logic [SQ_IN_W-1:0] bit_q;
	logic [SQ_IN_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			res_q <= '0;
			bit_q <= SQ_BIT_INIT;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[SQ_ROOT_W-1:0];

endmodule

// ===== src/ccr_div.sv =====
// ============================================================================
// Iterative unsigned divider
// Restoring division yielding a 16-bit quotient, one bit per cycle.
// ============================================================================
module ccr_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ccr_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [ccr_pkg::DIVISOR_W-1:0]  divisor,
	output logic                           done,
	output logic [ccr_pkg::QUOT_W-1:0]     quot
);

	import ccr_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [3:0]            cnt_q;
	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] dvs_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [DIVIDEND_W:0]   diff;

	assign diff = {1'b0, rem_q} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= {divisor[DIVISOR_W-1:0], 15'd0};
		end else if (busy_q) begin
			if (!diff[DIVIDEND_W]) begin
				rem_q <= diff[DIVIDEND_W-1:0];
			end
			quot_q <= {quot_q[QUOT_W-2:0], !diff[DIVIDEND_W]};
			dvs_q  <= dvs_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== src/ccr_datapath.sv =====
// ============================================================================
// Circle collision resolver datapath
// Circle stores, pair arithmetic, shared divider and square root, output word.
// ============================================================================
module ccr_datapath #(
	parameter int MAX_CIRCLES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ccr_pkg::COEF_W-1:0]     cfg_data,
	input  logic signed [ccr_pkg::POS_W-1:0] pos_x,
	input  logic signed [ccr_pkg::POS_W-1:0] pos_y,
	input  logic [ccr_pkg::RAD_W-1:0]      radius,
	input  ccr_pkg::ccr_cmd_t              cmd,
	output ccr_pkg::ccr_status_t           status,
	output logic [ccr_pkg::IDX_W-1:0]      index,
	output logic signed [ccr_pkg::POS_W-1:0] new_x,
	output logic signed [ccr_pkg::POS_W-1:0] new_y,
	output logic                           last_out
);

	import ccr_pkg::*;

	localparam int AW = $clog2(MAX_CIRCLES);

	logic [COEF_W-1:0]     coef_q;
	logic [AW-1:0]         ram_addr;
	logic                  we_x, we_y, we_r;
	logic [POS_W-1:0]      wdata_x, wdata_y;
	logic [POS_W-1:0]      rdata_x, rdata_y;
	logic [RAD_W-1:0]      rdata_r;

	logic [POS_W-1:0]      xi_q, yi_q, xj_q, yj_q;
	logic [RAD_W-1:0]      ri_q, rj_q;
	logic signed [32:0]    dx_q, dy_q;
	logic [16:0]           m_q;
	logic [32:0]           abs_dx, abs_dy;
	logic signed [17:0]    dx_n, dy_n;
	logic signed [35:0]    sq_x, sq_y;
	logic                  far_q;
	logic [33:0]           dx2_q, dy2_q, mm_q;
	logic [34:0]           d2;
	logic [34:0]           d2_q;
	logic                  near_q;
	logic [16:0]           len_q;
	logic [16:0]           ov;
	logic [32:0]           ovmul_q;
	logic [15:0]           push;
	logic [16:0]           adx_q, ady_q;
	logic [31:0]           wi_q, wj_q;
	logic [47:0]           ai_q, aj_q;
	logic [32:0]           wsum_q;
	logic [QUOT_W-1:0]     si_q, sj_q, uq_q;
	logic [32:0]           umul_q;

	logic                  sqrt_start;
	logic                  sqrt_done;
	logic [SQ_ROOT_W-1:0]  sqrt_root;
	logic                  div_start;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_dividend;
	logic [DIVISOR_W-1:0]  div_divisor;
	logic [QUOT_W-1:0]     div_quot;
	ccr_dest_t             dest_q;

	logic [POS_W-1:0]      upd_base;
	logic                  upd_neg;
	logic [33:0]           upd_delta;
	logic [33:0]           upd_sum;
	logic [POS_W-1:0]      upd_val;

	logic [IDX_W-1:0]      idx_q;
	logic [POS_W-1:0]      out_x_q, out_y_q;
	logic                  out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_we) begin
			coef_q <= cfg_data;
		end
	end

	assign ram_addr = cmd.addr[AW-1:0];
	assign we_x = (cmd.op == OP_LOAD_WR) || (cmd.op == OP_UPD_WR && !cmd.upd[0]);
	assign we_y = (cmd.op == OP_LOAD_WR) || (cmd.op == OP_UPD_WR && cmd.upd[0]);
	assign we_r = (cmd.op == OP_LOAD_WR);
	assign wdata_x = (cmd.op == OP_LOAD_WR) ? pos_x : upd_val;
	assign wdata_y = (cmd.op == OP_LOAD_WR) ? pos_y : upd_val;

	ccr_ram #(.WIDTH(POS_W), .DEPTH(MAX_CIRCLES)) u_x_store (
		.clk   (clk),
		.we    (we_x),
		.addr  (ram_addr),
		.wdata (wdata_x),
		.rdata (rdata_x)
	);

	ccr_ram #(.WIDTH(POS_W), .DEPTH(MAX_CIRCLES)) u_y_store (
		.clk   (clk),
		.we    (we_y),
		.addr  (ram_addr),
		.wdata (wdata_y),
		.rdata (rdata_y)
	);

	ccr_ram #(.WIDTH(RAD_W), .DEPTH(MAX_CIRCLES)) u_radius_store (
		.clk   (clk),
		.we    (we_r),
		.addr  (ram_addr),
		.wdata (radius),
		.rdata (rdata_r)
	);

	assign abs_dx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign abs_dy = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign dx_n   = dx_q[17:0];
	assign dy_n   = dy_q[17:0];
	assign sq_x   = dx_n * dx_n;
	assign sq_y   = dy_n * dy_n;
	assign d2     = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign ov     = m_q - len_q;
	assign push   = ovmul_q[32:17];

	assign sqrt_start = (cmd.op == OP_SQRT_START);

	ccr_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand ({1'b0, d2_q}),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	assign div_start = (cmd.op == OP_DIV_SI) || (cmd.op == OP_DIV_SJ) || (cmd.op == OP_UPD_DIV);

	always_comb begin
		case (cmd.op)
			OP_DIV_SI: begin
				div_dividend = ai_q;
				div_divisor  = wsum_q;
			end
			OP_DIV_SJ: begin
				div_dividend = aj_q;
				div_divisor  = wsum_q;
			end
			default: begin
				div_dividend = {15'd0, umul_q};
				div_divisor  = {16'd0, len_q};
			end
		endcase
	end

	ccr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		case (cmd.upd)
			2'd0:    upd_base = xi_q;
			2'd1:    upd_base = yi_q;
			2'd2:    upd_base = xj_q;
			default: upd_base = yj_q;
		endcase
		upd_neg   = (cmd.upd[0] ? dy_q[32] : dx_q[32]) ^ cmd.upd[1];
		upd_delta = upd_neg ? (34'd0 - {18'd0, uq_q}) : {18'd0, uq_q};
		upd_sum   = {{2{upd_base[31]}}, upd_base} + upd_delta;
		if (upd_sum[33:31] == 3'b000 || upd_sum[33:31] == 3'b111) begin
			upd_val = upd_sum[31:0];
		end else begin
			upd_val = upd_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAP_I: begin
				xi_q <= rdata_x;
				yi_q <= rdata_y;
				ri_q <= rdata_r;
			end
			OP_CAP_J: begin
				xj_q <= rdata_x;
				yj_q <= rdata_y;
				rj_q <= rdata_r;
			end
			OP_DIFF: begin
				dx_q <= $signed({xi_q[31], xi_q}) - $signed({xj_q[31], xj_q});
				dy_q <= $signed({yi_q[31], yi_q}) - $signed({yj_q[31], yj_q});
				m_q  <= {1'b0, ri_q} + {1'b0, rj_q};
			end
			OP_SQ: begin
				far_q <= (abs_dx >= {16'd0, m_q}) || (abs_dy >= {16'd0, m_q});
				dx2_q <= sq_x[33:0];
				dy2_q <= sq_y[33:0];
				mm_q  <= m_q * m_q;
			end
			OP_CMP: begin
				d2_q   <= d2;
				near_q <= !far_q && (d2 < {1'b0, mm_q});
			end
			OP_OV: begin
				ovmul_q <= coef_q * ov;
				adx_q   <= abs_dx[16:0];
				ady_q   <= abs_dy[16:0];
			end
			OP_WEIGHT: begin
				wi_q <= ri_q * ri_q;
				wj_q <= rj_q * rj_q;
			end
			OP_PROD: begin
				ai_q   <= push * wj_q;
				aj_q   <= push * wi_q;
				wsum_q <= {1'b0, wi_q} + {1'b0, wj_q};
			end
			OP_UPD_MUL: begin
				umul_q <= (cmd.upd[0] ? ady_q : adx_q) * (cmd.upd[1] ? sj_q : si_q);
			end
			default: begin
			end
		endcase
		if (sqrt_done) begin
			len_q <= sqrt_root[16:0];
		end
		if (div_done) begin
			case (dest_q)
				DEST_SI: si_q <= div_quot;
				DEST_SJ: sj_q <= div_quot;
				default: uq_q <= div_quot;
			endcase
		end
		if (cmd.out_load) begin
			idx_q      <= cmd.addr;
			out_x_q    <= rdata_x;
			out_y_q    <= rdata_y;
			out_last_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q <= DEST_SI;
		end else begin
			case (cmd.op)
				OP_DIV_SI:  dest_q <= DEST_SI;
				OP_DIV_SJ:  dest_q <= DEST_SJ;
				OP_UPD_DIV: dest_q <= DEST_Q;
				default:    dest_q <= dest_q;
			endcase
		end
	end

	assign status.sqrt_done = sqrt_done;
	assign status.div_done  = div_done;
	assign status.near      = near_q;
	assign status.len_zero  = (len_q == 17'd0);

	assign index    = idx_q;
	assign new_x    = out_x_q;
	assign new_y    = out_y_q;
	assign last_out = out_last_q;

endmodule

// ===== src/ccr_ctrl.sv =====
// ============================================================================
// Circle collision resolver controller
// Sequences loading, the all-pairs sweep and the output of a batch.
// ============================================================================
`include "circle_collision_resolver_top_macros.svh"

module ccr_ctrl #(
	parameter int MAX_CIRCLES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 last,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ccr_pkg::ccr_cmd_t    cmd,
	input  ccr_pkg::ccr_status_t status
);

	import ccr_pkg::*;

	localparam int AW = $clog2(MAX_CIRCLES);
	localparam int CW = $clog2(MAX_CIRCLES + 1);

	ccr_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_new;
	logic [AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [1:0]    u_q, u_d;
	logic          valid_q, valid_d;
	logic          room;
	logic          last_k, last_i, last_j;

	assign room    = cnt_q < CW'(MAX_CIRCLES);
	assign cnt_new = room ? cnt_q + CW'(1) : cnt_q;
	assign last_k  = CW'(k_q) == cnt_q - CW'(1);
	assign last_j  = CW'(j_q) == cnt_q - CW'(1);
	assign last_i  = CW'(i_q) == cnt_q - CW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			u_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			u_q     <= u_d;
			valid_q <= valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		i_d          = i_q;
		j_d          = j_q;
		k_d          = k_q;
		u_d          = u_q;
		valid_d      = valid_q;
		in_stall     = 1'b1;
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.upd      = u_q;
		case (state_q)
			S_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (room) begin
						cmd.op   = OP_LOAD_WR;
						cmd.addr = IDX_W'(cnt_q[AW-1:0]);
					end
					cnt_d = cnt_new;
					if (last) begin
						i_d = '0;
						j_d = AW'(1);
						k_d = '0;
						state_d = (cnt_new < CW'(2)) ? S_OUT_RD : S_RD_I;
					end
				end
			end
			S_RD_I: begin
				cmd.addr = IDX_W'(i_q);
				state_d  = S_RD_J;
			end
			S_RD_J: begin
				cmd.op   = OP_CAP_I;
				cmd.addr = IDX_W'(j_q);
				state_d  = S_CAP_J;
			end
			S_CAP_J: begin
				cmd.op  = OP_CAP_J;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op  = OP_SQ;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = OP_CMP;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (status.near) begin
					cmd.op  = OP_SQRT_START;
					state_d = S_SQRT_W;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_SQRT_W: begin
				if (status.sqrt_done) begin
					state_d = S_OV;
				end
			end
			S_OV: begin
				if (status.len_zero) begin
					state_d = S_NEXT;
				end else begin
					cmd.op  = OP_OV;
					u_d     = '0;
					state_d = S_WEIGHT;
				end
			end
			S_WEIGHT: begin
				cmd.op  = OP_WEIGHT;
				state_d = S_PROD;
			end
			S_PROD: begin
				cmd.op  = OP_PROD;
				state_d = S_DIV_SI;
			end
			S_DIV_SI: begin
				cmd.op  = OP_DIV_SI;
				state_d = S_DIV_SI_W;
			end
			S_DIV_SI_W: begin
				if (status.div_done) begin
					state_d = S_DIV_SJ;
				end
			end
			S_DIV_SJ: begin
				cmd.op  = OP_DIV_SJ;
				state_d = S_DIV_SJ_W;
			end
			S_DIV_SJ_W: begin
				if (status.div_done) begin
					state_d = S_UPD_MUL;
				end
			end
			S_UPD_MUL: begin
				cmd.op  = OP_UPD_MUL;
				state_d = S_UPD_DIV;
			end
			S_UPD_DIV: begin
				cmd.op  = OP_UPD_DIV;
				state_d = S_UPD_DIV_W;
			end
			S_UPD_DIV_W: begin
				if (status.div_done) begin
					state_d = S_UPD_WR;
				end
			end
			S_UPD_WR: begin
				cmd.op   = OP_UPD_WR;
				cmd.addr = u_q[1] ? IDX_W'(j_q) : IDX_W'(i_q);
				u_d      = u_q + 2'd1;
				state_d  = (u_q == 2'd3) ? S_NEXT : S_UPD_MUL;
			end
			S_NEXT: begin
				if (last_j) begin
					if (last_i) begin
						k_d     = '0;
						state_d = S_OUT_RD;
					end else begin
						i_d     = i_q + AW'(1);
						j_d     = i_q + AW'(1) + AW'(1);
						state_d = S_RD_I;
					end
				end else begin
					j_d     = j_q + AW'(1);
					state_d = S_RD_I;
				end
			end
			S_OUT_RD: begin
				cmd.addr = IDX_W'(k_q);
				state_d  = S_OUT_LD;
			end
			S_OUT_LD: begin
				cmd.addr     = IDX_W'(k_q);
				cmd.out_load = 1'b1;
				cmd.out_last = last_k;
				valid_d      = 1'b1;
				state_d      = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				if (!out_stall) begin
					valid_d = 1'b0;
					if (last_k) begin
						cnt_d   = '0;
						state_d = S_LOAD;
					end else begin
						k_d     = k_q + AW'(1);
						state_d = S_OUT_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	assign out_valid = valid_q;

	`CCR_ASSERT_ALWAYS(a_cnt_bound, clk, cnt_q <= CW'(MAX_CIRCLES), "batch count exceeds capacity")
	`CCR_ASSERT(a_pair_order, clk, arst_n, (state_q == S_RD_I) |-> (i_q < j_q && CW'(j_q) < cnt_q), "pair index out of order")
	`CCR_ASSERT(a_no_overlap, clk, arst_n, (!in_stall) |-> (!out_valid), "input taken while a word is pending")
	`CCR_ASSERT(a_batch_clear, clk, arst_n, (state_q == S_OUT_WAIT && !out_stall && last_k) |=> (cnt_q == '0 && state_q == S_LOAD), "batch not cleared after final word")

endmodule

// ===== src/circle_collision_resolver_top.sv =====
// ============================================================================
// Circle collision resolver
// Loads a batch of circles, resolves all overlapping pairs and emits the batch.
// ============================================================================
// Circles are taken one per cycle while loading; a word flagged last starts
// resolution. The sweep then visits every pair in index order; a pair that
// overlaps runs the square root and, unless its centres coincide, six
// divisions that share one divider, with all circle data in single-port
// stores. Each resolved circle then leaves as one output word, held while
// the output is stalled. No new circle is taken until the last word of the
// batch has been delivered.
module circle_collision_resolver_top #(
	parameter int MAX_CIRCLES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ccr_pkg::COEF_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ccr_pkg::POS_W-1:0]  pos_x,
	input  logic signed [ccr_pkg::POS_W-1:0]  pos_y,
	input  logic [ccr_pkg::RAD_W-1:0]         radius,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ccr_pkg::IDX_W-1:0]         index,
	output logic signed [ccr_pkg::POS_W-1:0]  new_x,
	output logic signed [ccr_pkg::POS_W-1:0]  new_y,
	output logic                              last_out
);

	import ccr_pkg::*;

	ccr_cmd_t    cmd;
	ccr_status_t status;

	ccr_ctrl #(.MAX_CIRCLES(MAX_CIRCLES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	ccr_datapath #(.MAX_CIRCLES(MAX_CIRCLES)) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.radius   (radius),
		.cmd      (cmd),
		.status   (status),
		.index    (index),
		.new_x    (new_x),
		.new_y    (new_y),
		.last_out (last_out)
	);

endmodule
